/* rtl/pidm_pkg.sv */
`default_nettype none

package pidm_pkg;

  // fixed word widths of gains, drive and integral sum
  localparam int unsigned WORD_W    = 32;
  // full-precision accumulator, wide enough for sum of all products
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM      = 3'd4;

  typedef enum logic [1:0] {
    MODE_PID  = 2'd0,
    MODE_FF   = 2'd1,
    MODE_TBH  = 2'd2,
    MODE_BANG = 2'd3
  } loop_mode_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] prop_gain;
    logic signed [WORD_W-1:0] integral_gain;
    logic signed [WORD_W-1:0] deriv_gain;
    loop_mode_t               loop_mode;
    logic                     accumulate_drive;
  } cfg_t;

  typedef struct packed {
    logic enable;
    logic clear;
    logic load_ff;
  } tick_flags_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] drive;
    logic                     running;
    logic                     saturated;
  } result_t;

endpackage

`default_nettype wire

/* rtl/pidm_in_stage.sv */
`default_nettype none

module pidm_in_stage #(
  parameter int unsigned MEAS_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [MEAS_WIDTH-1:0]   in_measurement,
  input  wire logic signed [MEAS_WIDTH-1:0]   in_target,
  input  wire pidm_pkg::tick_flags_t          in_flags,
  input  wire logic signed [31:0]             in_ff_value,
  input  wire logic                           advance,
  output logic                                s_valid,
  output logic signed [MEAS_WIDTH-1:0]        s_measurement,
  output logic signed [MEAS_WIDTH-1:0]        s_target,
  output pidm_pkg::tick_flags_t               s_flags,
  output logic signed [31:0]                  s_ff_value
);
  import pidm_pkg::*;

  logic                         valid_r, valid_nxt;
  logic signed [MEAS_WIDTH-1:0] meas_r, tgt_r;
  tick_flags_t                  flags_r;
  logic signed [WORD_W-1:0]     ffv_r;
  logic                         load;

  assign in_ready  = !valid_r || advance;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      meas_r  <= in_measurement;
      tgt_r   <= in_target;
      flags_r <= in_flags;
      ffv_r   <= in_ff_value;
    end
  end

  assign s_valid       = valid_r;
  assign s_measurement = meas_r;
  assign s_target      = tgt_r;
  assign s_flags       = flags_r;
  assign s_ff_value    = ffv_r;

endmodule

`default_nettype wire

/* rtl/pidm_step.sv */
`default_nettype none

module pidm_step #(
  parameter int unsigned MEAS_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         commit,
  input  wire pidm_pkg::cfg_t               cfg,
  input  wire logic signed [MEAS_WIDTH-1:0] meas,
  input  wire logic signed [MEAS_WIDTH-1:0] tgt,
  input  wire pidm_pkg::tick_flags_t        flags,
  input  wire logic signed [31:0]           ff_value,
  output pidm_pkg::result_t                 res
);
  import pidm_pkg::*;

  localparam int unsigned ERR_W  = MEAS_WIDTH + 1;
  localparam int unsigned DIFF_W = MEAS_WIDTH + 2;
  localparam int unsigned P_W    = ERR_W + WORD_W;
  localparam int unsigned D_W    = DIFF_W + WORD_W;
  localparam int unsigned I_W    = 2 * WORD_W;
  localparam logic signed [WORD_W-1:0] DRIVE_ONE = 32'sd1 <<< FRAC_BITS;

  // controller state
  logic signed [WORD_W-1:0] sum_r, sum_nxt;
  logic signed [ERR_W-1:0]  last_r, last_nxt;
  logic signed [WORD_W-1:0] ff_r, ff_nxt;
  logic signed [WORD_W-1:0] drive_r, drive_nxt;

  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [WORD_W:0]   sum_wide;
  logic signed [WORD_W-1:0] sum_sat;
  logic                     sum_clip;
  logic signed [WORD_W-1:0] ff_cur;
  logic signed [WORD_W:0]   ff_pair;
  logic                     sign_flip;
  logic signed [WORD_W-1:0] ff_use;
  logic signed [P_W-1:0]    p_prod;
  logic signed [I_W-1:0]    i_prod;
  logic signed [D_W-1:0]    d_prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-WORD_W:0]    acc_hi;
  logic                     acc_clip;
  logic signed [WORD_W-1:0] acc_sat;
  logic                     use_ff;

  always_comb begin
    err      = ERR_W'(tgt) - ERR_W'(meas);
    err_diff = DIFF_W'(err) - DIFF_W'(last_r);

    sum_wide = (WORD_W+1)'(sum_r) + (WORD_W+1)'(err);
    sum_clip = sum_wide[WORD_W] != sum_wide[WORD_W-1];
    sum_sat  = sum_clip ? (sum_wide[WORD_W] ? S32_MIN : S32_MAX) : sum_wide[WORD_W-1:0];

    ff_cur   = flags.load_ff ? ff_value : ff_r;
    // take-back-half: floor average of feedforward and last drive
    ff_pair  = (WORD_W+1)'(ff_cur) + (WORD_W+1)'(drive_r);
    sign_flip = (err == '0) ||
                (err[ERR_W-1] && !last_r[ERR_W-1] && (last_r != '0)) ||
                (!err[ERR_W-1] && (err != '0) && last_r[ERR_W-1]);
    ff_use   = (cfg.loop_mode == MODE_TBH && sign_flip) ? ff_pair[WORD_W:1] : ff_cur;

    p_prod = err * cfg.prop_gain;
    i_prod = sum_sat * cfg.integral_gain;
    d_prod = err_diff * cfg.deriv_gain;

    use_ff = (cfg.loop_mode == MODE_FF) || (cfg.loop_mode == MODE_TBH);
    acc = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod)
        + (cfg.accumulate_drive ? ACC_W'(drive_r) : '0)
        + (use_ff ? ACC_W'(ff_use) : '0);

    acc_hi   = acc[ACC_W-1:WORD_W-1];
    acc_clip = !((&acc_hi) || !(|acc_hi));
    acc_sat  = acc_clip ? (acc[ACC_W-1] ? S32_MIN : S32_MAX) : acc[WORD_W-1:0];
  end

  // next state and result
  always_comb begin
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    ff_nxt        = ff_cur;
    drive_nxt     = '0;
    res.running   = 1'b0;
    res.saturated = 1'b0;
    if (flags.clear) begin
      sum_nxt  = '0;
      last_nxt = '0;
    end else if (flags.enable) begin
      sum_nxt     = sum_sat;
      last_nxt    = err;
      ff_nxt      = ff_use;
      res.running = 1'b1;
      if (cfg.loop_mode == MODE_BANG) begin
        drive_nxt     = (err > 0) ? DRIVE_ONE : '0;
        res.saturated = sum_clip;
      end else begin
        drive_nxt     = acc_sat;
        res.saturated = sum_clip || acc_clip;
      end
    end
    res.drive = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      last_r  <= '0;
      ff_r    <= '0;
      drive_r <= '0;
    end else if (commit) begin
      sum_r   <= sum_nxt;
      last_r  <= last_nxt;
      ff_r    <= ff_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/pidm_out_stage.sv */
`default_nettype none

module pidm_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s_valid,
  input  wire pidm_pkg::result_t  s_res,
  output logic                    advance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_drive,
  output logic                    out_running,
  output logic                    out_saturated
);
  import pidm_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  // output register frees when empty or when its beat is taken
  assign advance   = !valid_r || out_ready;
  assign load      = s_valid && advance;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= s_res;
    end
  end

  assign out_valid     = valid_r;
  assign out_drive     = res_r.drive;
  assign out_running   = res_r.running;
  assign out_saturated = res_r.saturated;

endmodule

`default_nettype wire

/* rtl/pid_controller_multi_mode.sv */
// an input beat passes the input register, the step logic and the result register
// throughput: one control tick per cycle unless the result stalls; the integral sum,
//   last error, feedforward term and drive feed back through a single-pass datapath
// reset (rst_n, synchronous, active low): gains, mode and accumulate flag clear
//   to zero, controller state clears to zero, both pipeline registers empty
`default_nettype none

module pid_controller_multi_mode #(
  parameter int unsigned MEAS_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tick channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [MEAS_WIDTH-1:0]        in_measurement,
  input  wire logic signed [MEAS_WIDTH-1:0]        in_target,
  input  wire logic                                in_enable,
  input  wire logic                                in_clear,
  input  wire logic                                in_load_feedforward,
  input  wire logic signed [31:0]                  in_feedforward_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [31:0]                       out_drive,
  output logic                                     out_running,
  output logic                                     out_saturated,
  // configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [pidm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [31:0]                         cfg_wdata
);
  import pidm_pkg::*;

  // configuration registers; write them only while idle, the block does not enforce this
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROP_GAIN:  cfg_nxt.prop_gain        = cfg_wdata;
        REG_INTEG_GAIN: cfg_nxt.integral_gain    = cfg_wdata;
        REG_DERIV_GAIN: cfg_nxt.deriv_gain       = cfg_wdata;
        REG_LOOP_MODE:  cfg_nxt.loop_mode        = loop_mode_t'(cfg_wdata[1:0]);
        REG_ACCUM:      cfg_nxt.accumulate_drive = cfg_wdata[0];
        default: begin
          // unmapped index, write dropped
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register stage
  tick_flags_t                  in_flags, s_flags;
  logic                         s_valid;
  logic signed [MEAS_WIDTH-1:0] s_measurement, s_target;
  logic signed [WORD_W-1:0]     s_ff_value;
  logic                         advance;
  logic                         commit;
  result_t                      s_res;

  assign in_flags.enable  = in_enable;
  assign in_flags.clear   = in_clear;
  assign in_flags.load_ff = in_load_feedforward;

  pidm_in_stage #(
    .MEAS_WIDTH (MEAS_WIDTH)
  ) u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_measurement (in_measurement),
    .in_target      (in_target),
    .in_flags       (in_flags),
    .in_ff_value    (in_feedforward_value),
    .advance        (advance),
    .s_valid        (s_valid),
    .s_measurement  (s_measurement),
    .s_target       (s_target),
    .s_flags        (s_flags),
    .s_ff_value     (s_ff_value)
  );

  // controller state moves exactly when a tick passes into the output register
  assign commit = s_valid && advance;

  pidm_step #(
    .MEAS_WIDTH (MEAS_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (commit),
    .cfg      (cfg_r),
    .meas     (s_measurement),
    .tgt      (s_target),
    .flags    (s_flags),
    .ff_value (s_ff_value),
    .res      (s_res)
  );

  // result register, parts the two handshakes
  pidm_out_stage u_out_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_valid       (s_valid),
    .s_res         (s_res),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_running   (out_running),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

/* rtl/pidm_checker.sv */
`default_nettype none

module pidm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_drive,
  input wire logic        out_running,
  input wire logic        out_saturated
);

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // input side only backs up behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a skipped step always reports zero drive and no clipping
  a_idle_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> out_drive == 32'd0 && !out_saturated)
    else $error("non-running beat with drive or saturation set");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)
      && $stable(out_running) && $stable(out_saturated))
    else $error("result beat changed while stalled");

endmodule

bind pid_controller_multi_mode pidm_checker u_pidm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_drive     (out_drive),
  .out_running   (out_running),
  .out_saturated (out_saturated)
);

`default_nettype wire

/* bench/pid_controller_multi_mode_tb.sv */
`default_nettype none

module pid_controller_multi_mode_tb;
  import pidm_pkg::*;

  localparam int unsigned FRAC     = 16;   // matches the default FRAC_BITS of the block
  localparam longint      ONE_Q    = longint'(1) << FRAC;
  localparam longint      WORD_MAX = 64'sd2147483647;
  localparam longint      WORD_MIN = -64'sd2147483648;
  localparam int          PHASES   = 8;
  localparam int          PER_PHASE = 231;
  localparam int          HOLD_LEN = 300;

  // one control tick as it goes onto the input channel
  typedef struct {
    logic signed [15:0] measurement;
    logic signed [15:0] target;
    tick_flags_t        flags;
    logic signed [31:0] ff_value;
  } tick_t;

  // one line of the directed plan; typed rows carry their own answer
  typedef struct {
    int      sel;
    tick_t   tick;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_measurement = '0;
  logic signed [15:0] in_target = '0;
  logic               in_enable = 1'b0;
  logic               in_clear = 1'b0;
  logic               in_load_feedforward = 1'b0;
  logic signed [31:0] in_feedforward_value = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_drive;
  logic               out_running;
  logic               out_saturated;

  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  pid_controller_multi_mode u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measurement       (in_measurement),
    .in_target            (in_target),
    .in_enable            (in_enable),
    .in_clear             (in_clear),
    .in_load_feedforward  (in_load_feedforward),
    .in_feedforward_value (in_feedforward_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_drive            (out_drive),
    .out_running          (out_running),
    .out_saturated        (out_saturated),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller copy kept by the bench, all cleared as after reset
  cfg_t   ctl_cfg = '0;
  longint sum_state = 0;
  longint prev_err = 0;
  longint ff_state = 0;
  longint drive_state = 0;

  result_t tick_results_q[$];   // expected result beats, oldest first
  int      mismatches = 0;
  int      results_seen = 0;
  bit      no_idle = 1'b0;      // set for a stretch where neither side idles

  function automatic longint clip32(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // advance the controller copy by one tick and return the beat it should produce
  function automatic result_t control_tick(input tick_t t);
    longint  meas;
    longint  tgt;
    longint  err;
    longint  raw;
    longint  pid_sum;
    bit      hit;
    result_t r;
    meas = longint'($signed(t.measurement));
    tgt  = longint'($signed(t.target));
    hit  = 1'b0;
    r    = '0;
    // the feedforward load lands first, whatever else the tick asks
    if (t.flags.load_ff) ff_state = longint'($signed(t.ff_value));
    if (t.flags.clear) begin
      sum_state   = 0;
      prev_err    = 0;
      drive_state = 0;
    end else if (!t.flags.enable) begin
      drive_state = 0;
    end else begin
      err = tgt - meas;
      r.running = 1'b1;
      raw = sum_state + err;
      sum_state = clip32(raw);
      hit = (sum_state != raw);
      // take-back-half: zero error or a sign flip pulls the term toward the drive
      if (ctl_cfg.loop_mode == MODE_TBH &&
          (err == 0 || (err < 0 && prev_err > 0) || (err > 0 && prev_err < 0)))
        ff_state = (ff_state + drive_state) >>> 1;
      pid_sum = err * longint'($signed(ctl_cfg.prop_gain))
              + sum_state * longint'($signed(ctl_cfg.integral_gain))
              + (err - prev_err) * longint'($signed(ctl_cfg.deriv_gain));
      if (ctl_cfg.accumulate_drive) pid_sum += drive_state;
      if (ctl_cfg.loop_mode == MODE_FF || ctl_cfg.loop_mode == MODE_TBH)
        pid_sum += ff_state;
      if (ctl_cfg.loop_mode == MODE_BANG) begin
        // bang-bang ignores the sum, so only the integral clip shows
        drive_state = (meas < tgt) ? ONE_Q : 0;
      end else begin
        drive_state = clip32(pid_sum);
        hit |= (drive_state != pid_sum);
      end
      prev_err = err;
    end
    r.drive     = drive_state[31:0];
    r.saturated = hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // one config write per cycle; the caller lowers the enable after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  ctl_cfg.prop_gain = data;
      REG_INTEG_GAIN: ctl_cfg.integral_gain = data;
      REG_DERIV_GAIN: ctl_cfg.deriv_gain = data;
      REG_LOOP_MODE:  ctl_cfg.loop_mode = loop_mode_t'(data[1:0]);
      REG_ACCUM:      ctl_cfg.accumulate_drive = data[0];
      default: ;  // unused indexes are dropped by the block
    endcase
  endtask

  task automatic apply_config(input cfg_t c, input bit with_stray);
    logic [31:0] fill;
    fill = $urandom();
    // a write to an unused index must leave everything alone
    if (with_stray)
      write_reg(CFG_IDX_W'($urandom_range(REG_ACCUM + 1, (1 << CFG_IDX_W) - 1)), $urandom());
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEG_GAIN, c.integral_gain);
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    // upper data bits are junk for the narrow registers
    write_reg(REG_LOOP_MODE, {fill[31:2], c.loop_mode});
    write_reg(REG_ACCUM, {fill[31:1], c.accumulate_drive});
    cfg_wr_en <= 1'b0;
  endtask

  // stop offering and wait until every expected beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  // offer one tick, hold it until accepted, then queue its expected beat
  task automatic send_tick(input tick_t t, input bit typed, input result_t want);
    result_t predicted;
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_measurement       <= t.measurement;
    in_target            <= t.target;
    in_enable            <= t.flags.enable;
    in_clear             <= t.flags.clear;
    in_load_feedforward  <= t.flags.load_ff;
    in_feedforward_value <= t.ff_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = control_tick(t);
    tick_results_q.push_back(typed ? want : predicted);
  endtask

  function automatic plan_row_t plan_row(input int sel, input int meas, input int tgt,
                                         input bit en, input bit clr, input bit ld,
                                         input logic [31:0] ffv, input bit typed,
                                         input logic [31:0] d, input bit run,
                                         input bit sat);
    plan_row_t p;
    p.sel                 = sel;
    p.tick.measurement    = 16'(meas);
    p.tick.target         = 16'(tgt);
    p.tick.flags.enable   = en;
    p.tick.flags.clear    = clr;
    p.tick.flags.load_ff  = ld;
    p.tick.ff_value       = ffv;
    p.typed               = typed;
    p.want.drive          = d;
    p.want.running        = run;
    p.want.saturated      = sat;
    return p;
  endfunction

  // settings used by the directed plan
  function automatic cfg_t plan_cfg(input int sel);
    cfg_t c;
    c = '0;
    case (sel)
      1: c.prop_gain = 32'sh0001_0000;          // unit gain, drive = error
      2: begin
        c.prop_gain        = S32_MAX;
        c.integral_gain    = S32_MAX;
        c.deriv_gain       = S32_MIN;
        c.loop_mode        = MODE_BANG;
        c.accumulate_drive = 1'b1;
      end
      3: begin
        c.prop_gain        = 32'sh0000_8000;
        c.integral_gain    = 32'sh0000_0100;
        c.deriv_gain       = S32_MIN;
        c.loop_mode        = MODE_TBH;
        c.accumulate_drive = 1'b1;
      end
      4: begin
        c.prop_gain  = S32_MIN;
        c.deriv_gain = 32'sh0001_0000;
        c.loop_mode  = MODE_FF;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] pick_gain();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = S32_MAX;
      2: v = S32_MIN;
      3, 4: v = $urandom();
      default: begin
        v = $urandom_range(0, 32'h3_ffff);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic cfg_t random_cfg(input int phase);
    cfg_t c;
    c.prop_gain     = pick_gain();
    c.integral_gain = pick_gain();
    c.deriv_gain    = pick_gain();
    if (phase == 2) begin
      c.prop_gain = S32_MAX; c.integral_gain = S32_MAX; c.deriv_gain = S32_MAX;
    end
    if (phase == 5) begin
      c.prop_gain = S32_MIN; c.integral_gain = S32_MIN; c.deriv_gain = S32_MIN;
    end
    c.loop_mode        = loop_mode_t'(phase % 4);
    c.accumulate_drive = $urandom_range(1);
    return c;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    k;
    int    center;
    k = $urandom_range(99);
    if (k < 20) begin
      t.measurement = 16'($urandom());
      t.target      = 16'($urandom());
    end else if (k < 30) begin
      t.measurement = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      t.target      = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end else begin
      // near a common point so the error is small, often zero and flips sign
      center        = int'($urandom_range(0, 4000)) - 2000;
      t.measurement = 16'(center + int'($urandom_range(0, 16)) - 8);
      t.target      = 16'(center + int'($urandom_range(0, 16)) - 8);
    end
    t.flags.enable  = ($urandom_range(99) >= 8);
    t.flags.clear   = ($urandom_range(99) < 4);
    t.flags.load_ff = ($urandom_range(99) < 20);
    if ($urandom_range(1)) begin
      t.ff_value = $urandom();
    end else begin
      t.ff_value = $urandom_range(0, 32'h7_ffff);
      if ($urandom_range(1)) t.ff_value = -t.ff_value;
    end
    return t;
  endfunction

  // result side: check each beat, stall at random, and hold off twice for a long stretch
  initial begin : result_side
    result_t want;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          report_mismatch("beat with nothing pending", out_drive, '0);
        end else begin
          want = tick_results_q.pop_front();
          if (out_drive !== want.drive) report_mismatch("drive", out_drive, want.drive);
          if (out_running !== want.running)
            report_mismatch("running", 32'(out_running), 32'(want.running));
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_saturated), 32'(want.saturated));
        end
        results_seen++;
        // long hold while ticks keep coming, so the pipe fills and in_ready drops
        if (results_seen == 600 || results_seen == 1400) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < 19) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // tick side: directed plan, then random phases
  initial begin : tick_side
    plan_row_t plan_rows[$];
    cfg_t      c;
    int        cur_sel;
    int        phase;
    int        n;

    // reset settings, gains all zero: every drive reads zero
    plan_rows.push_back(plan_row(0, 0, 0, 1, 0, 0, 0, 1, 32'h0, 1, 0));
    plan_rows.push_back(plan_row(0, -32768, 32767, 1, 0, 0, 0, 1, 32'h0, 1, 0));
    // disabled tick forces the drive low and skips the step
    plan_rows.push_back(plan_row(0, 100, 200, 0, 0, 0, 0, 1, 32'h0, 0, 0));
    // clear wins over enable
    plan_rows.push_back(plan_row(0, 5, 9, 1, 1, 0, 0, 1, 32'h0, 0, 0));
    // feedforward load while disabled
    plan_rows.push_back(plan_row(0, 0, 0, 0, 0, 1, 32'h7fff_ffff, 1, 32'h0, 0, 0));
    // unit gain: full-scale error clips the drive both ways
    plan_rows.push_back(plan_row(1, -32768, 32767, 1, 0, 0, 0, 1, 32'h7fff_ffff, 1, 1));
    plan_rows.push_back(plan_row(1, 32767, -32768, 1, 0, 0, 0, 1, 32'h8000_0000, 1, 1));
    plan_rows.push_back(plan_row(1, 5, 7, 1, 0, 0, 0, 1, 32'h0002_0000, 1, 0));
    // clear with a feedforward load of the most negative term
    plan_rows.push_back(plan_row(1, 0, 0, 1, 1, 1, 32'h8000_0000, 1, 32'h0, 0, 0));
    // bang-bang: one when below target, else zero
    plan_rows.push_back(plan_row(2, -1, 0, 1, 0, 0, 0, 1, 32'h0001_0000, 1, 0));
    plan_rows.push_back(plan_row(2, 0, 0, 1, 0, 0, 0, 1, 32'h0, 1, 0));
    plan_rows.push_back(plan_row(2, 32767, -32768, 1, 0, 0, 0, 1, 32'h0, 1, 0));
    plan_rows.push_back(plan_row(2, -32768, 32767, 1, 0, 0, 0, 1, 32'h0001_0000, 1, 0));
    // take-back-half: sign flips, zero error, no flip from zero, zero right after a load
    plan_rows.push_back(plan_row(3, 0, 10, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(3, 20, 10, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(3, 10, 10, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(3, 10, 30, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(3, 0, 0, 1, 0, 1, 32'h1234_5678, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(3, -32768, 32767, 1, 0, 0, 0, 0, 0, 0, 0));
    // feedforward mode with the most negative proportional gain
    plan_rows.push_back(plan_row(4, 3, 1, 1, 0, 1, 32'h00ab_cdef, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(4, 1, 3, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(4, -32768, 32767, 1, 0, 0, 0, 0, 0, 0, 0));
    plan_rows.push_back(plan_row(4, 32767, -32768, 1, 0, 0, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_sel = -1;
    foreach (plan_rows[i]) begin
      if (plan_rows[i].sel != cur_sel) begin
        settle();
        apply_config(plan_cfg(plan_rows[i].sel), 1'b0);
        cur_sel = plan_rows[i].sel;
      end
      send_tick(plan_rows[i].tick, plan_rows[i].typed, plan_rows[i].want);
    end

    // random phases, each with its own settings; every mode comes up twice
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      c = random_cfg(phase);
      apply_config(c, 1'b1);
      no_idle = (phase == 3);
      for (n = 0; n < PER_PHASE; n++) begin
        // now and then the sender waits for every beat to come home
        if ($urandom_range(199) == 0) settle();
        send_tick(rand_tick(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    // keep clocking a while longer to catch stray beats
    repeat (10) @(posedge clk);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("pid_controller_multi_mode_tb passed");
    end else begin
      $display("pid_controller_multi_mode_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("pid_controller_multi_mode_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
